// ----- sv/rbcc_pkg.sv -----
// Shared types, register codes and arithmetic helpers of the backlight color cycler.
package rbcc_pkg;

    localparam int NUM_LEDS_DEF  = 3;
    localparam int IDX_W         = 2;
    localparam int ADDR_W        = 5;

    localparam logic [8:0] HUE_CIRCLE    = 9'd360;
    localparam logic [8:0] OFFSET_RESET  = 9'd80;
    localparam logic [7:0] LEVEL_RESET   = 8'd123;
    localparam logic [8:0] PHASE_RED     = 9'd300;
    localparam logic [8:0] PHASE_GREEN   = 9'd180;
    localparam logic [8:0] PHASE_BLUE    = 9'd60;

    localparam logic [1:0] MODE_CONST   = 2'd0;
    localparam logic [1:0] MODE_SINGLE  = 2'd1;
    localparam logic [1:0] MODE_RAINBOW = 2'd2;

    localparam logic [0:0] ACT_TICK   = 1'b0;
    localparam logic [0:0] ACT_RENDER = 1'b1;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_STEP   = 3'd2,
        REG_ENABLE = 3'd3,
        REG_LED0   = 3'd4,
        REG_LED1   = 3'd5,
        REG_LED2   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [8:0]        width;
        logic signed [7:0] step;
        logic              spin_en;
        logic [2:0][23:0]  led_color;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HUE,
        ST_DIST,
        ST_LEVEL,
        ST_SCALE
    } state_t;

    typedef struct packed {
        logic             update;
        logic             hue_en;
        logic             dist_en;
        logic             level_en;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic any_color;
        logic out_free;
    } stat_t;

    // Reduce a value below three full circles into 0..359.
    function automatic logic [8:0] hue_wrap(input logic [9:0] v);
        logic [9:0] r;
        if (v >= 10'd720) begin
            r = v - 10'd720;
        end else if (v >= 10'd360) begin
            r = v - 10'd360;
        end else begin
            r = v;
        end
        return r[8:0];
    endfunction

    // Distance of a channel from its peak, clamped to 0..60.
    function automatic logic [5:0] hue_dist(input logic [8:0] hue, input logic [8:0] phase);
        logic [9:0] x;
        logic [9:0] d;
        x = 10'(hue) + 10'(phase);
        if (x >= 10'd360) begin
            x = x - 10'd360;
        end
        if (x > 10'd120) begin
            d = (x >= 10'd240) ? 10'd0 : 10'd240 - x;
        end else begin
            d = x;
        end
        if (d > 10'd60) begin
            d = 10'd60;
        end
        return d[5:0];
    endfunction

    // 255 - ceil(153*d/40); divide by 8, then by 5 through 1639/8192.
    function automatic logic [7:0] dist_level(input logic [5:0] d);
        logic [13:0] n;
        logic [21:0] p;
        n = 14'(d) * 14'd153 + 14'd39;
        p = 22'(n[13:3]) * 22'd1639;
        return 8'd255 - p[20:13];
    endfunction

    // floor(c*lvl/255), exact for any 16-bit product.
    function automatic logic [7:0] scale255(input logic [7:0] c, input logic [7:0] lvl);
        logic [15:0] p;
        logic [15:0] s;
        p = 16'(c) * 16'(lvl);
        s = p + 16'(p[15:8]) + 16'd1;
        return s[15:8];
    endfunction

endpackage

// ----- sv/rbcc_regs.sv -----
// Configuration register file with the APB-style access port.
module rbcc_regs
    import rbcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_CONST;
            cfg_reg.width     <= 9'd270;
            cfg_reg.step      <= 8'sd10;
            cfg_reg.spin_en   <= 1'b1;
            cfg_reg.led_color <= {3{24'hFF4F00}};
        end else if (wr_en) begin
            case (idx)
                REG_MODE:   cfg_reg.mode         <= pwdata[1:0];
                REG_WIDTH:  cfg_reg.width        <= pwdata[8:0];
                REG_STEP:   cfg_reg.step         <= pwdata[7:0];
                REG_ENABLE: cfg_reg.spin_en      <= pwdata[0];
                REG_LED0:   cfg_reg.led_color[0] <= pwdata[23:0];
                REG_LED1:   cfg_reg.led_color[1] <= pwdata[23:0];
                REG_LED2:   cfg_reg.led_color[2] <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MODE:   prdata = 32'(cfg_reg.mode);
            REG_WIDTH:  prdata = 32'(cfg_reg.width);
            REG_STEP:   prdata = 32'(unsigned'(cfg_reg.step));
            REG_ENABLE: prdata = 32'(cfg_reg.spin_en);
            REG_LED0:   prdata = 32'(cfg_reg.led_color[0]);
            REG_LED1:   prdata = 32'(cfg_reg.led_color[1]);
            REG_LED2:   prdata = 32'(cfg_reg.led_color[2]);
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/rbcc_ctrl.sv -----
// Sequencer that walks each word through hue, distance, level and scale steps per LED.
module rbcc_ctrl
    import rbcc_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.idx      = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.update = 1'b1;
                    idx_next   = '0;
                    if (stat.any_color) begin
                        state_next = ST_HUE;
                    end
                end
            end
            ST_HUE: begin
                cmd.hue_en = 1'b1;
                state_next = ST_DIST;
            end
            ST_DIST: begin
                cmd.dist_en = 1'b1;
                state_next  = ST_LEVEL;
            end
            ST_LEVEL: begin
                cmd.level_en = 1'b1;
                state_next   = ST_SCALE;
            end
            ST_SCALE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_HUE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- sv/rbcc_dp.sv -----
// Datapath: hue offset, held level, rainbow curve, scaling and the output register.
module rbcc_dp
    import rbcc_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        in_action,
    input  logic [7:0]  in_level,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

    logic [8:0]  offset_reg, offset_next;
    logic [7:0]  level_reg, level_next;
    logic        out_valid_reg;
    logic [8:0]  hue_reg;
    logic [5:0]  dr_reg, dg_reg, db_reg;
    logic [7:0]  cr_reg, cg_reg, cb_reg;
    logic [23:0] out_data_reg;
    logic [1:0]  out_slot_reg;
    logic        out_last_reg;

    logic [2:0]  pos;
    logic [8:0]  spread;
    logic [9:0]  tick_sum;
    logic [23:0] fixed;

    always_comb begin
        offset_next = offset_reg;
        level_next  = level_reg;
        tick_sum    = 10'(offset_reg) + 10'(HUE_CIRCLE) + {{2{cfg.step[7]}}, cfg.step};
        if (cmd.update) begin
            if (in_action == ACT_RENDER) begin
                level_next = in_level;
            end else if (cfg.spin_en) begin
                offset_next = hue_wrap(tick_sum);
            end
        end
    end

    always_comb begin
        case (cfg.mode)
            MODE_SINGLE:  pos = 3'd4;
            MODE_RAINBOW: pos = 3'd2 + {cmd.idx, 1'b0};
            default:      pos = 3'd0;
        endcase
        spread = 9'(pos) * {3'd0, cfg.width[8:3]};
        case (cmd.idx)
            2'd0:    fixed = cfg.led_color[0];
            2'd1:    fixed = cfg.led_color[1];
            2'd2:    fixed = cfg.led_color[2];
            default: fixed = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= OFFSET_RESET;
            level_reg     <= LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            level_reg  <= level_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hue_en) begin
            hue_reg <= hue_wrap(10'(offset_reg) + 10'(spread));
        end
        if (cmd.dist_en) begin
            dr_reg <= hue_dist(hue_reg, PHASE_RED);
            dg_reg <= hue_dist(hue_reg, PHASE_GREEN);
            db_reg <= hue_dist(hue_reg, PHASE_BLUE);
        end
        if (cmd.level_en) begin
            if (cfg.mode == MODE_CONST) begin
                cr_reg <= fixed[23:16];
                cg_reg <= fixed[15:8];
                cb_reg <= fixed[7:0];
            end else begin
                cr_reg <= dist_level(dr_reg);
                cg_reg <= dist_level(dg_reg);
                cb_reg <= dist_level(db_reg);
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= {scale255(cb_reg, level_reg), scale255(cg_reg, level_reg),
                             scale255(cr_reg, level_reg)};
            out_slot_reg <= 2'(LAST_IDX - cmd.idx);
            out_last_reg <= (cmd.idx == LAST_IDX);
        end
    end

    assign stat.any_color = |cfg.led_color;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_slot_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/rainbow_backlight_color_cycler.sv -----
// Top level of the rainbow backlight color cycler.
//
//  channel  dir  handshake                fields (lowest bit up)
//  s_       in   s_tvalid/s_tready        tuser: action; tdata: level
//  m_       out  m_tvalid/m_tready        tuser: led_slot; tdata: red, green, blue;
//                                         tlast: last
//  cfg      in   psel/penable/pwrite      APB-style, register i at byte address 4*i
//
// A word is taken in the idle state, then each LED passes in turn through the hue,
// distance, level and scale registers. Reset is synchronous; no clearing pass,
// input is ready right after reset. A held result stalls only the scale step; the
// last result waits in the output register while the next word is taken. With all
// fixed colors zero a word yields no result and the sequencer stays idle.
module rainbow_backlight_color_cycler
    import rbcc_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // level
    input  logic              s_tuser,   // action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // red, green, blue
    output logic [1:0]        m_tuser,   // led_slot
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    rbcc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbcc_ctrl #(.NUM_LEDS(NUM_LEDS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbcc_dp #(.NUM_LEDS(NUM_LEDS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .in_action (s_tuser),
        .in_level  (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && cfg.led_color != '0) |=> !s_tready)
        else $error("input ready during rendering");

    a_last_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == 2'd0))
        else $error("last word not on slot zero");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tuser) < 32'(NUM_LEDS)))
        else $error("slot beyond LED count");

endmodule

// ----- test/tb.sv -----
// Testbench for the rainbow backlight color cycler: directed and random words checked against a predictor.
module tb
    import rbcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int READY_ALWAYS  = 0;
    localparam int READY_RANDOM  = 1;
    localparam int READY_PATTERN = 2;
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic [1:0] slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } led_word_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // level
    logic              s_tuser  = 1'b0; // action
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;         // red, green, blue
    logic [1:0]        m_tuser;         // led_slot
    logic              m_tlast;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    led_word_t pending_leds[$];
    int        err_count   = 0;
    int        ready_style = READY_ALWAYS;
    int        ready_phase = 0;
    int        hold_len    = 0;
    bit        gaps_on     = 1'b1;
    int        burst_left  = 0;

    logic [1:0]        mode_r;
    logic [8:0]        width_r;
    logic signed [7:0] step_r;
    logic              spin_r;
    logic [23:0]       color_r [3];
    int                hue_pos;
    logic [7:0]        bright;

    rainbow_backlight_color_cycler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [7:0] channel_curve(input int hue, input int phase);
        int x;
        int d;
        x = (hue + phase) % 360;
        if (x > 120) begin
            d = (x >= 240) ? 0 : 240 - x;
        end else begin
            d = x;
        end
        if (d > 60) begin
            d = 60;
        end
        return 8'(255 - (153 * d + 39) / 40);
    endfunction

    function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] lvl);
        return 8'((int'(c) * int'(lvl)) / 255);
    endfunction

    function automatic void predict_leds(input logic act, input logic [7:0] lvl);
        int        pos;
        int        hue;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        led_word_t w;
        if (act == ACT_TICK) begin
            if (spin_r) begin
                hue_pos = (hue_pos + 360 + int'(step_r)) % 360;
            end
        end else begin
            bright = lvl;
        end
        if ((color_r[0] | color_r[1] | color_r[2]) == 24'd0) begin
            return;
        end
        for (int i = 0; i < 3; i++) begin
            if (mode_r == MODE_CONST) begin
                r = color_r[i][23:16];
                g = color_r[i][15:8];
                b = color_r[i][7:0];
            end else begin
                if (mode_r == MODE_SINGLE) begin
                    pos = 4;
                end else if (mode_r == MODE_RAINBOW) begin
                    pos = 2 + 2 * i;
                end else begin
                    pos = 0;
                end
                hue = (hue_pos + pos * (int'(width_r) / 8)) % 360;
                r = channel_curve(hue, int'(PHASE_RED));
                g = channel_curve(hue, int'(PHASE_GREEN));
                b = channel_curve(hue, int'(PHASE_BLUE));
            end
            w.slot  = 2'(2 - i);
            w.red   = dim(r, bright);
            w.green = dim(g, bright);
            w.blue  = dim(b, bright);
            w.last  = (i == 2);
            pending_leds.push_back(w);
        end
    endfunction

    function automatic void flag(input string field, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        led_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_leds.size() == 0) begin
                $error("unexpected LED word: slot %0d data %06h", m_tuser, m_tdata);
                err_count++;
            end else begin
                w = pending_leds.pop_front();
                flag("led_slot", w.slot, m_tuser);
                flag("red", w.red, m_tdata[7:0]);
                flag("green", w.green, m_tdata[15:8]);
                flag("blue", w.blue, m_tdata[23:16]);
                flag("last", w.last, m_tlast);
            end
        end
    end

    always @(negedge aclk) begin
        ready_phase++;
        if (hold_len > 0) begin
            hold_len--;
            m_tready <= 1'b0;
        end else begin
            case (ready_style)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:      m_tready <= ((ready_phase % 9) < 5);
            endcase
        end
    end

    initial begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_word(input logic act, input logic [7:0] lvl);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= lvl;
        do @(posedge aclk); while (!s_tready);
        predict_leds(act, lvl);
    endtask

    // Drop valid, drain every pending word, then let the pipeline go quiet.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_leds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:   mode_r     = val[1:0];
            REG_WIDTH:  width_r    = val[8:0];
            REG_STEP:   step_r     = val[7:0];
            REG_ENABLE: spin_r     = val[0];
            REG_LED0:   color_r[0] = val[23:0];
            REG_LED1:   color_r[1] = val[23:0];
            REG_LED2:   color_r[2] = val[23:0];
            default: ;
        endcase
    endtask

    task automatic set_colors(input logic [23:0] c0, input logic [23:0] c1,
                              input logic [23:0] c2);
        cfg_write(REG_LED0, 32'(c0));
        cfg_write(REG_LED1, 32'(c1));
        cfg_write(REG_LED2, 32'(c2));
    endtask

    task automatic test_reset_state();
        ready_style = READY_ALWAYS;
        send_word(ACT_TICK, 8'h5A);
        send_word(ACT_RENDER, 8'hFF);
        send_word(ACT_RENDER, 8'h00);
        settle();
    endtask

    task automatic test_fixed_colors();
        ready_style = READY_PATTERN;
        set_colors(24'hFFFFFF, 24'h000000, 24'h80017F);
        send_word(ACT_RENDER, 8'hFF);
        send_word(ACT_RENDER, 8'h01);
        send_word(ACT_TICK, 8'hAA);
        settle();
    endtask

    task automatic test_dark_strip();
        set_colors(24'h000000, 24'h000000, 24'h000000);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_TICK, 8'hFF);
        send_word(ACT_RENDER, 8'd200);
        settle();
        cfg_write(REG_MODE, 32'(MODE_RAINBOW));
        set_colors(24'h000001, 24'h000000, 24'h000000);
        send_word(ACT_TICK, 8'h00);
        settle();
    endtask

    task automatic test_hue_modes();
        ready_style = READY_RANDOM;
        cfg_write(REG_MODE, 32'(MODE_SINGLE));
        cfg_write(REG_WIDTH, 32'd270);
        cfg_write(REG_STEP, 32'h7F);
        cfg_write(REG_ENABLE, 32'd1);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_RENDER, 8'hFF);
        settle();
        cfg_write(REG_MODE, 32'(MODE_RAINBOW));
        cfg_write(REG_WIDTH, 32'd360);
        send_word(ACT_TICK, 8'h00);
        settle();
        cfg_write(REG_WIDTH, 32'd0);
        send_word(ACT_TICK, 8'h00);
        settle();
        cfg_write(REG_WIDTH, 32'd511);
        cfg_write(REG_STEP, 32'h80);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_TICK, 8'h00);
        settle();
        cfg_write(REG_MODE, 32'd3);
        send_word(ACT_TICK, 8'h00);
        settle();
        cfg_write(REG_ENABLE, 32'd0);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_RENDER, 8'd77);
        settle();
    endtask

    task automatic test_backpressure();
        cfg_write(REG_MODE, 32'(MODE_RAINBOW));
        cfg_write(REG_ENABLE, 32'd1);
        cfg_write(REG_STEP, 32'd37);
        set_colors(24'h123456, 24'h0, 24'hFEDCBA);
        ready_style = READY_ALWAYS;
        @(posedge aclk);
        hold_len = 300;
        gaps_on = 1'b0;
        repeat (12) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        gaps_on = 1'b1;
        settle();
    endtask

    task automatic test_random_phases();
        logic [23:0] c [3];
        for (int p = 0; p < 6; p++) begin
            cfg_write(REG_MODE, 32'($urandom_range(0, 3)));
            cfg_write(REG_WIDTH, 32'($urandom_range(0, 511)));
            cfg_write(REG_STEP, 32'($urandom_range(0, 255)));
            cfg_write(REG_ENABLE, 32'($urandom_range(0, 3) != 0));
            for (int i = 0; i < 3; i++) begin
                c[i] = ($urandom_range(0, 4) == 0) ? 24'd0 : 24'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                c[0] = 24'd0;
                c[1] = 24'd0;
                c[2] = 24'd0;
            end
            set_colors(c[0], c[1], c[2]);
            ready_style = $urandom_range(READY_ALWAYS, READY_PATTERN);
            repeat (17) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            settle();
        end
    endtask

    initial begin
        mode_r     = MODE_CONST;
        width_r    = 9'd270;
        step_r     = 8'sd10;
        spin_r     = 1'b1;
        color_r[0] = 24'hFF4F00;
        color_r[1] = 24'hFF4F00;
        color_r[2] = 24'hFF4F00;
        hue_pos    = int'(OFFSET_RESET);
        bright     = LEVEL_RESET;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_fixed_colors();
        test_dark_strip();
        test_hue_modes();
        test_backpressure();
        test_random_phases();
        settle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
